/* design/days_to_calendar_date_assert.svh */
// Assertion macros for days_to_calendar_date, which checks its own behavior.
// Each macro expands to one labeled concurrent assertion, clocked on the
// rising edge and disabled while reset is asserted.
`ifndef DAYS_TO_CALENDAR_DATE_ASSERT_SVH
`define DAYS_TO_CALENDAR_DATE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DTCD_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define DTCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* design/dtcd_pkg.sv */
package dtcd_pkg;

    localparam int unsigned EPOCH_YEAR      = 1978;
    localparam int unsigned MINUTES_PER_DAY = 1440;
    localparam int unsigned MINUTES_PER_HOUR = 60;

    // floor(m / 60) == (m * 2185) >> 17 for every m below one day.
    localparam int unsigned HOUR_RECIP = 2185;
    localparam int unsigned HOUR_SHIFT = 17;

    localparam int unsigned YEAR_DAYS      = 365;
    localparam int unsigned LEAP_YEAR_DAYS = 366;

    // Residues of the epoch year for the leap rule counters.
    localparam logic [1:0] EPOCH_MOD4   = 2'(EPOCH_YEAR % 4);
    localparam logic [6:0] EPOCH_MOD100 = 7'(EPOCH_YEAR % 100);
    localparam logic [8:0] EPOCH_MOD400 = 9'(EPOCH_YEAR % 400);

    // Month indexes, zero based.
    localparam logic [3:0] MON_JAN = 4'd0;
    localparam logic [3:0] MON_FEB = 4'd1;
    localparam logic [3:0] MON_APR = 4'd3;
    localparam logic [3:0] MON_JUN = 4'd5;
    localparam logic [3:0] MON_SEP = 4'd8;
    localparam logic [3:0] MON_NOV = 4'd10;
    localparam logic [3:0] MON_DEC = 4'd11;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_YEAR,
        ST_MONTH,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;        // capture a new item
        logic year_step;   // take one whole year off the day count
        logic month_step;  // take one month off the day count
        logic time_step;   // register the hour of the captured minute count
    } ctrl_cmd_t;

    typedef struct packed {
        logic year_fits;   // remaining days fall inside the current year
        logic month_fits;  // remaining days fall inside the current month
    } dp_status_t;

    function automatic logic [4:0] month_len_days(input logic [3:0] mon, input logic leap);
        logic [4:0] len;
        begin
            case (mon) inside
                MON_FEB:                          len = leap ? 5'd29 : 5'd28;
                MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
                default:                          len = 5'd31;
            endcase
            return len;
        end
    endfunction

endpackage

/* design/days_to_calendar_date.sv */
// Converts a day count since 1 January 1978 and a minute-of-day count into a
// Gregorian year, month, day of month, hour and minute.
// An item is taken at a rising edge where start is high and busy is low;
// day_count and minute_of_day are sampled at that edge and need not be held.
// The block then removes whole years one per cycle, then whole months one
// per cycle, and then raises done. One item is in work at a time.
// The result is valid on year, month, day_of_month, hour and minute for exactly
// the one cycle in which done is high; the receiver cannot stall it.
// Busy is low in that cycle, so the next item may be accepted on the same edge.
// Minute counts of 1440 or more wrap once to the same day; years past 4095
// wrap modulo 4096. Reset returns the controller to idle with no result
// pending; no clearing pass is needed.
module days_to_calendar_date #(
    parameter int DAY_COUNT_BITS = 17
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [DAY_COUNT_BITS-1:0] day_count,
    input  logic [10:0]               minute_of_day,
    output logic                      done,
    output logic [11:0]               year,
    output logic [3:0]                month,
    output logic [4:0]                day_of_month,
    output logic [4:0]                hour,
    output logic [5:0]                minute
);
    import dtcd_pkg::*;

    `include "days_to_calendar_date_assert.svh"

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // The controller sequences the year and month phases.
    dtcd_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // The datapath holds the running day count, year and month, and the
    // leap rule counters that track the year modulo 4, 100 and 400.
    dtcd_dpath #(
        .DAY_COUNT_BITS (DAY_COUNT_BITS)
    ) u_dpath (
        .clk           (clk),
        .cmd           (cmd),
        .day_count     (day_count),
        .minute_of_day (minute_of_day),
        .status        (status),
        .year          (year),
        .month         (month),
        .day_of_month  (day_of_month),
        .hour          (hour),
        .minute        (minute)
    );

    // An accepted item always keeps the block busy in the next cycle.
    `DTCD_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy && !done)

    // The result strobe lasts exactly one cycle.
    `DTCD_ASSERT_NEXT(a_done_pulse, clk, rst_n, done, !done)

    // A delivered date lies within a calendar month.
    `DTCD_ASSERT_SAME(a_date_range, clk, rst_n, done,
        (month >= 4'd1) && (month <= 4'd12) && (day_of_month >= 5'd1))

    // A delivered time of day is in range.
    `DTCD_ASSERT_SAME(a_time_range, clk, rst_n, done, (hour < 5'd24) && (minute < 6'd60))

endmodule

/* design/dtcd_ctrl.sv */
module dtcd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  dtcd_pkg::dp_status_t status,
    output dtcd_pkg::ctrl_cmd_t  cmd,
    output logic                busy,
    output logic                done
);
    import dtcd_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE, ST_DONE:
            begin
                state_next = start ? ST_YEAR : ST_IDLE;
            end
            ST_YEAR:
            begin
                if (status.year_fits)
                begin
                    state_next = ST_MONTH;
                end
            end
            ST_MONTH:
            begin
                if (status.month_fits)
                begin
                    state_next = ST_DONE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b0;
        done = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load = start;
            end
            ST_YEAR:
            begin
                busy          = 1'b1;
                cmd.time_step = 1'b1;
                cmd.year_step = !status.year_fits;
            end
            ST_MONTH:
            begin
                busy           = 1'b1;
                cmd.month_step = !status.month_fits;
            end
            ST_DONE:
            begin
                done     = 1'b1;
                cmd.load = start;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

endmodule

/* design/dtcd_dpath.sv */
module dtcd_dpath #(
    parameter int DAY_COUNT_BITS = 17
) (
    input  logic                      clk,
    input  dtcd_pkg::ctrl_cmd_t       cmd,
    input  logic [DAY_COUNT_BITS-1:0] day_count,
    input  logic [10:0]               minute_of_day,
    output dtcd_pkg::dp_status_t      status,
    output logic [11:0]               year,
    output logic [3:0]                month,
    output logic [4:0]                day_of_month,
    output logic [4:0]                hour,
    output logic [5:0]                minute
);
    import dtcd_pkg::*;

    logic [DAY_COUNT_BITS-1:0] days_reg;
    logic [11:0]               year_reg;
    logic [1:0]                y4_reg;
    logic [6:0]                y100_reg;
    logic [8:0]                y400_reg;
    logic [3:0]                mon_reg;
    logic [10:0]               mins_reg;
    logic [4:0]                hour_reg;

    logic                      leap;
    logic [8:0]                ylen;
    logic [4:0]                mlen;
    logic [10:0]               mins_wrapped;
    logic [22:0]               hour_prod;
    logic [10:0]               hour_minutes;

    assign leap = (y4_reg == 2'd0) && ((y100_reg != 7'd0) || (y400_reg == 9'd0));
    assign ylen = leap ? 9'(LEAP_YEAR_DAYS) : 9'(YEAR_DAYS);
    assign mlen = month_len_days(mon_reg, leap);

    assign status.year_fits  = days_reg < DAY_COUNT_BITS'(ylen);
    assign status.month_fits = (mon_reg == MON_DEC) || (days_reg < DAY_COUNT_BITS'(mlen));

    // A minute count of one day or more wraps once; 2047 is the largest input.
    assign mins_wrapped = (minute_of_day >= 11'(MINUTES_PER_DAY))
                        ? 11'(minute_of_day - 11'(MINUTES_PER_DAY))
                        : minute_of_day;

    assign hour_prod    = 23'(mins_reg) * 23'(HOUR_RECIP);
    assign hour_minutes = 11'(hour_reg) * 11'(MINUTES_PER_HOUR);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            days_reg <= day_count;
            year_reg <= 12'(EPOCH_YEAR);
            y4_reg   <= EPOCH_MOD4;
            y100_reg <= EPOCH_MOD100;
            y400_reg <= EPOCH_MOD400;
            mon_reg  <= MON_JAN;
            mins_reg <= mins_wrapped;
        end
        else if (cmd.year_step)
        begin
            days_reg <= days_reg - DAY_COUNT_BITS'(ylen);
            year_reg <= year_reg + 12'd1;
            y4_reg   <= y4_reg + 2'd1;
            y100_reg <= (y100_reg == 7'd99) ? 7'd0 : y100_reg + 7'd1;
            y400_reg <= (y400_reg == 9'd399) ? 9'd0 : y400_reg + 9'd1;
        end
        else if (cmd.month_step)
        begin
            days_reg <= days_reg - DAY_COUNT_BITS'(mlen);
            mon_reg  <= mon_reg + 4'd1;
        end

        if (cmd.time_step)
        begin
            hour_reg <= hour_prod[HOUR_SHIFT +: 5];
        end
    end

    assign year         = year_reg;
    assign month        = mon_reg + 4'd1;
    assign day_of_month = 5'(days_reg) + 5'd1;
    assign hour         = hour_reg;
    assign minute       = 6'(mins_reg - hour_minutes);

endmodule
